[rtl/input_side_fir_convolver_top_defines.svh]
// assertion macros used by isfc_ctrl
`ifndef INPUT_SIDE_FIR_CONVOLVER_TOP_DEFINES_SVH
`define INPUT_SIDE_FIR_CONVOLVER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define ISFC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ISFC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/isfc_pkg.sv]
package isfc_pkg;

    localparam int MAX_TAPS = 64;
    localparam int IDX_W    = $clog2(MAX_TAPS);
    localparam int TAP_W    = IDX_W + 1;
    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = 2 * SAMPLE_W;
    localparam int ACC_W    = 40;

    localparam logic [TAP_W-1:0] TAP_COUNT_RESET = TAP_W'(MAX_TAPS);

    // item opcodes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef struct packed {
        logic             latch_item;
        logic             coef_wr;
        logic             mac_issue;
        logic [IDX_W-1:0] mac_index;
        logic             emit_rd;
        logic             emit_load;
        logic             emit_last;
    } isfc_cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } isfc_stat_t;

    // zero acts as one, anything above the store depth acts as the depth
    function automatic logic [TAP_W-1:0] active_taps(input logic [TAP_W-1:0] raw);
        logic [TAP_W-1:0] res;
        res = raw;
        if (raw == '0)
        begin
            res = TAP_W'(1);
        end
        else if (raw > TAP_W'(MAX_TAPS))
        begin
            res = TAP_W'(MAX_TAPS);
        end
        return res;
    endfunction

endpackage

[rtl/isfc_in_if.sv]
interface isfc_in_if
    import isfc_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic                       op;
    logic [IDX_W-1:0]           coef_index;
    logic signed [SAMPLE_W-1:0] value;
    logic                       end_of_signal;

    modport source (output valid, output op, output coef_index, output value,
                    output end_of_signal, input ready);
    modport sink   (input valid, input op, input coef_index, input value,
                    input end_of_signal, output ready);
endinterface

[rtl/isfc_out_if.sv]
interface isfc_out_if
    import isfc_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [ACC_W-1:0] out_value;
    logic                    out_last;

    modport source (output valid, output out_value, output out_last, input ready);
    modport sink   (input valid, input out_value, input out_last, output ready);
endinterface

[rtl/input_side_fir_convolver_top.sv]
// channel   | dir | transfer payload                        | handshake
// ----------+-----+-----------------------------------------+-------------
// in_ch     | in  | op, coef_index, value, end_of_signal    | valid/ready
// out_ch    | out | out_value, out_last                     | valid/ready
// cfg       | in  | cfg_data (tap_count)                    | cfg_we
//
// a load transfer writes its coefficient when it is accepted; a sample is walked
// by the single shared multiply-accumulate, one tap per cycle
// an end-of-signal sample also emits the taps - 1 tail sums
// rst_n is asynchronous; the ring of partial sums reads as zero right after
// reset through per-entry valid bits, so no clearing pass is needed
// a stalled output holds the block only when the next sum is due; a sample
// may be taken while the last result still sits in the output register
module input_side_fir_convolver_top
    import isfc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    isfc_in_if.sink          in_ch,
    isfc_out_if.source       out_ch,
    input  logic             cfg_we,
    input  logic [TAP_W-1:0] cfg_data
);

    // command and status between sequencer and datapath
    isfc_cmd_t  cmd;
    isfc_stat_t stat;

    // sequencer: accepts transfers, walks taps, paces emits and tail drain
    isfc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_op    (in_ch.op),
        .in_eos   (in_ch.end_of_signal),
        .in_ready (in_ch.ready),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: coefficient store, partial sum ring, mac pipe, output register
    isfc_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .in_coef_index (in_ch.coef_index),
        .in_value      (in_ch.value),
        .out_ready     (out_ch.ready),
        .stat          (stat),
        .out_valid     (out_ch.valid),
        .out_value     (out_ch.out_value),
        .out_last      (out_ch.out_last)
    );

endmodule

[rtl/isfc_dp.sv]
module isfc_dp
    import isfc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  isfc_cmd_t                  cmd,
    input  logic [IDX_W-1:0]           in_coef_index,
    input  logic signed [SAMPLE_W-1:0] in_value,
    input  logic                       out_ready,
    output isfc_stat_t                 stat,
    output logic                       out_valid,
    output logic signed [ACC_W-1:0]    out_value,
    output logic                       out_last
);

    logic signed [SAMPLE_W-1:0] coef_mem [MAX_TAPS];
    logic signed [ACC_W-1:0]    psum_mem [MAX_TAPS];

    logic [MAX_TAPS-1:0]        psum_valid_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [SAMPLE_W-1:0] coef_rd_reg;
    logic signed [ACC_W-1:0]    psum_rd_reg;
    logic                       psv_rd_reg;
    logic [IDX_W-1:0]           head_reg;

    logic                       v_s1_reg;
    logic                       v_s2_reg;
    logic [IDX_W-1:0]           pos_s1_reg;
    logic [IDX_W-1:0]           pos_s2_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_s2_reg;

    logic                       out_valid_reg;
    logic signed [ACC_W-1:0]    out_value_reg;
    logic                       out_last_reg;

    logic [IDX_W-1:0]           rd_addr;
    logic signed [ACC_W-1:0]    sum;

    assign rd_addr = cmd.emit_rd ? head_reg : head_reg + cmd.mac_index;
    assign sum     = acc_s2_reg + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    // coefficient store
    always_ff @(posedge clk)
    begin
        if (cmd.coef_wr)
        begin
            coef_mem[in_coef_index] <= in_value;
        end
        coef_rd_reg <= coef_mem[cmd.mac_index];
    end

    // partial sum ring
    always_ff @(posedge clk)
    begin
        if (v_s2_reg)
        begin
            psum_mem[pos_s2_reg] <= sum;
        end
        psum_rd_reg <= psum_mem[rd_addr];
        psv_rd_reg  <= psum_valid_reg[rd_addr];
    end

    // mac payload stages
    always_ff @(posedge clk)
    begin
        if (cmd.latch_item)
        begin
            x_reg <= in_value;
        end
        pos_s1_reg <= rd_addr;
        pos_s2_reg <= pos_s1_reg;
        prod_reg   <= x_reg * coef_rd_reg;
        acc_s2_reg <= psv_rd_reg ? psum_rd_reg : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_s1_reg       <= 1'b0;
            v_s2_reg       <= 1'b0;
            head_reg       <= '0;
            psum_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            v_s1_reg <= cmd.mac_issue;
            v_s2_reg <= v_s1_reg;
            if (v_s2_reg)
            begin
                psum_valid_reg[pos_s2_reg] <= 1'b1;
            end
            if (cmd.emit_load)
            begin
                psum_valid_reg[head_reg] <= 1'b0;
                head_reg                 <= head_reg + IDX_W'(1);
                out_valid_reg            <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_load)
        begin
            out_value_reg <= psv_rd_reg ? psum_rd_reg : '0;
            out_last_reg  <= cmd.emit_last;
        end
    end

    assign stat.pipe_busy = v_s1_reg | v_s2_reg;
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;

endmodule

[rtl/isfc_ctrl.sv]
module isfc_ctrl
    import isfc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_op,
    input  logic             in_eos,
    output logic             in_ready,
    input  logic             cfg_we,
    input  logic [TAP_W-1:0] cfg_data,
    input  isfc_stat_t       stat,
    output isfc_cmd_t        cmd
);

`include "input_side_fir_convolver_top_defines.svh"

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_MAC     = 3'd1;
    localparam logic [2:0] ST_FLUSH   = 3'd2;
    localparam logic [2:0] ST_EMIT_RD = 3'd3;
    localparam logic [2:0] ST_EMIT_LD = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [TAP_W-1:0] tap_count_reg;
    logic [TAP_W-1:0] taps_reg, taps_next;
    logic             eos_reg, eos_next;
    logic [TAP_W-1:0] m_reg, m_next;
    logic [TAP_W-1:0] drain_reg, drain_next;
    logic             accept;
    logic             at_last_emit;

    assign in_ready     = (state_reg == ST_IDLE);
    assign accept       = in_valid && in_ready;
    assign at_last_emit = eos_reg && (drain_reg == taps_reg - TAP_W'(1));

    always_comb
    begin
        state_next     = state_reg;
        taps_next      = taps_reg;
        eos_next       = eos_reg;
        m_next         = m_reg;
        drain_next     = drain_reg;
        cmd            = '0;
        cmd.mac_index  = m_reg[IDX_W-1:0];
        cmd.emit_last  = at_last_emit;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_op == OP_LOAD)
                    begin
                        cmd.coef_wr = 1'b1;
                    end
                    else
                    begin
                        cmd.latch_item = 1'b1;
                        taps_next      = active_taps(tap_count_reg);
                        eos_next       = in_eos;
                        m_next         = '0;
                        drain_next     = '0;
                        state_next     = ST_MAC;
                    end
                end
            end
            ST_MAC:
            begin
                cmd.mac_issue = 1'b1;
                if (m_reg == taps_reg - TAP_W'(1))
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    m_next = m_reg + TAP_W'(1);
                end
            end
            ST_FLUSH:
            begin
                if (!stat.pipe_busy)
                begin
                    state_next = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD:
            begin
                cmd.emit_rd = 1'b1;
                state_next  = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                // keep the ring read on the head while the output is stalled
                cmd.emit_rd = 1'b1;
                if (stat.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    if (eos_reg && !at_last_emit)
                    begin
                        drain_next = drain_reg + TAP_W'(1);
                        state_next = ST_EMIT_RD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tap_count_reg <= TAP_COUNT_RESET;
            taps_reg      <= TAP_W'(1);
            eos_reg       <= 1'b0;
            m_reg         <= '0;
            drain_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            taps_reg  <= taps_next;
            eos_reg   <= eos_next;
            m_reg     <= m_next;
            drain_reg <= drain_next;
            if (cfg_we)
            begin
                tap_count_reg <= cfg_data;
            end
        end
    end

    `ISFC_ASSERT_NOW(a_emit_into_free_slot, cmd.emit_load, stat.out_free, "emit while output busy")
    `ISFC_ASSERT_NOW(a_tap_in_range, cmd.mac_issue, TAP_W'(cmd.mac_index) < taps_reg, "tap past count")
    `ISFC_ASSERT_NOW(a_read_after_flush, cmd.emit_rd, !stat.pipe_busy, "ring read before mac done")
    `ISFC_ASSERT_NEXT(a_sample_starts_mac, accept && (in_op == OP_SAMPLE), state_reg == ST_MAC, "no mac")

endmodule
